// File: hw/rtl/dedc_pkg.sv
// dedc_pkg: shared constants, types and table functions for the domain entropy classifier
// used by every rtl file of the block; no dependencies
`default_nettype none

package dedc_pkg;

	localparam int unsigned MAX_NAME_LEN_DEF = 255;
	localparam int unsigned FRAC_BITS_DEF    = 12;

	localparam int unsigned CH_W    = 8;
	localparam int unsigned LEN_W   = 8;
	localparam int unsigned ENT_W   = 15;
	localparam int unsigned CAUSE_W = 3;
	localparam int unsigned CFG_IDX_W  = 8;
	localparam int unsigned CFG_DATA_W = 15;

	typedef enum logic [CAUSE_W-1:0] {
		CAUSE_NONE    = 3'd0,
		CAUSE_ENTROPY = 3'd1,
		CAUSE_DIGITS  = 3'd2,
		CAUSE_LETTERS = 3'd3,
		CAUSE_LABEL   = 3'd4
	} cause_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THRESHOLD = 8'd0,
		REG_MIN_LEN   = 8'd1
	} reg_idx_t;

	localparam logic [ENT_W-1:0]      THRESHOLD_RST = 15'd14336;
	localparam logic [LEN_W-1:0]      MIN_LEN_RST   = 8'd8;

	typedef struct packed {
		logic accept;
		logic update;
		logic prep;
		logic step;
		logic finish;
	} dedc_cmd_t;

	typedef struct packed {
		logic last;
		logic out_free;
	} dedc_stat_t;

	// log2 of an 8-bit value with 30 fraction bits, by repeated squaring
	function automatic logic [63:0] log2_q30(input int unsigned x);
		int unsigned xv;
		int unsigned n;
		logic [63:0] m;
		logic [63:0] fr;
		xv = x & 32'hFF;
		if (xv == 0)
			xv = 1;
		n = 0;
		for (int i = 0; i < 8; i++) begin
			if ((xv >> i) > 1)
				n = i + 1;
		end
		m = 64'(xv) << (30 - n);
		fr = '0;
		for (int i = 0; i < 30; i++) begin
			m = (m * m) >> 30;
			fr = fr << 1;
			if (m >= (64'd1 << 31)) begin
				m = m >> 1;
				fr = fr | 64'd1;
			end
		end
		return (64'(n) << 30) | fr;
	endfunction

	// c*log2(c) rounded half up to frac fraction bits
	function automatic logic [63:0] clog_term(input int unsigned c, input int unsigned frac);
		if (c < 2)
			return '0;
		return (64'(c) * log2_q30(c) + (64'd1 << (29 - frac))) >> (30 - frac);
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/dedc_if.sv
// dedc interfaces: byte input, result output and register write channels
// depends on dedc_pkg
`default_nettype none

interface dedc_in_if;
	logic                      valid;
	logic                      ready;
	logic [dedc_pkg::CH_W-1:0] ch;
	logic                      last;
	modport source (output valid, ch, last, input ready);
	modport sink (input valid, ch, last, output ready);
endinterface

interface dedc_out_if;
	logic                         valid;
	logic                         ready;
	logic                         is_dga;
	logic [dedc_pkg::CAUSE_W-1:0] cause;
	logic [dedc_pkg::ENT_W-1:0]   entropy_q;
	logic [dedc_pkg::LEN_W-1:0]   name_length;
	logic                         too_long;
	modport source (output valid, is_dga, cause, entropy_q, name_length, too_long,
		input ready);
	modport sink (input valid, is_dga, cause, entropy_q, name_length, too_long,
		output ready);
endinterface

interface dedc_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [dedc_pkg::CFG_IDX_W-1:0]  index;
	logic [dedc_pkg::CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/dga_domain_entropy_classifier_top.sv
// channel      dir  handshake        payload
// byte_in      in   valid/ready      ch[7:0], last
// result_out   out  valid/ready      is_dga, cause[2:0], entropy_q[14:0], name_length[7:0],
//                                    too_long
// cfg          in   valid/ready      index[7:0], data[14:0]
//
// each byte: histogram memory read on accept, then read-modify-write of the count
// the last byte then passes through divider prep, the bit-serial entropy divider and the finish
// state; a result still waiting in the output register holds the next result load, and the
// byte input waits with it. reset clears count valid bits at once, no memory sweep; cfg is
// always ready
// top level of the domain entropy classifier; depends on dedc_pkg, dedc_if, dedc_ctrl, dedc_datapath
`default_nettype none

module dga_domain_entropy_classifier_top #(
	parameter int unsigned MAX_NAME_LEN = dedc_pkg::MAX_NAME_LEN_DEF,
	parameter int unsigned FRAC_BITS    = dedc_pkg::FRAC_BITS_DEF
) (
	input wire          clk,
	input wire          arst_n,
	dedc_in_if.sink     byte_in,
	dedc_out_if.source  result_out,
	dedc_cfg_if.sink    cfg
);
	import dedc_pkg::*;

	localparam int unsigned SUM_W = FRAC_BITS + 12;

	dedc_cmd_t  cmd;
	dedc_stat_t stat;

	assign cfg.ready = 1'b1;

	dedc_ctrl #(
		.SUM_W(SUM_W)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(byte_in.valid),
		.in_ready(byte_in.ready),
		.stat    (stat),
		.cmd     (cmd)
	);

	dedc_datapath #(
		.MAX_NAME_LEN(MAX_NAME_LEN),
		.FRAC_BITS   (FRAC_BITS),
		.SUM_W       (SUM_W)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.in_ch       (byte_in.ch),
		.in_last     (byte_in.last),
		.cfg_we      (cfg.valid && cfg.ready),
		.cfg_idx     (cfg.index),
		.cfg_data    (cfg.data),
		.out_ready   (result_out.ready),
		.out_valid   (result_out.valid),
		.out_is_dga  (result_out.is_dga),
		.out_cause   (result_out.cause),
		.out_entropy (result_out.entropy_q),
		.out_length  (result_out.name_length),
		.out_too_long(result_out.too_long)
	);

endmodule

`default_nettype wire

// File: hw/rtl/dedc_ctrl.sv
// dedc_ctrl: sequencer for histogram update, entropy division and result load
// depends on dedc_pkg
`default_nettype none

module dedc_ctrl #(
	parameter int unsigned SUM_W = 24
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       in_valid,
	output logic                      in_ready,
	input  wire dedc_pkg::dedc_stat_t stat,
	output dedc_pkg::dedc_cmd_t       cmd
);
	import dedc_pkg::*;

	localparam int unsigned CNT_W = $clog2(SUM_W);

	typedef enum logic [2:0] {
		S_IDLE,
		S_UPD,
		S_PREP,
		S_DIV,
		S_FIN
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;

	assign in_ready   = (state_q == S_IDLE);
	assign cmd.accept = in_ready && in_valid;
	assign cmd.update = (state_q == S_UPD);
	assign cmd.prep   = (state_q == S_PREP);
	assign cmd.step   = (state_q == S_DIV);
	assign cmd.finish = (state_q == S_FIN) && stat.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid)
						state_q <= S_UPD;
				end
				S_UPD: begin
					state_q <= stat.last ? S_PREP : S_IDLE;
				end
				S_PREP: begin
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(SUM_W - 1))
						state_q <= S_FIN;
				end
				S_FIN: begin
					if (stat.out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/dedc_datapath.sv
// dedc_datapath: histogram memory, log-sum, pattern trackers, divider and result register
// depends on dedc_pkg
`default_nettype none

module dedc_datapath #(
	parameter int unsigned MAX_NAME_LEN = dedc_pkg::MAX_NAME_LEN_DEF,
	parameter int unsigned FRAC_BITS    = dedc_pkg::FRAC_BITS_DEF,
	parameter int unsigned SUM_W        = FRAC_BITS + 12
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire dedc_pkg::dedc_cmd_t            cmd,
	output dedc_pkg::dedc_stat_t                stat,
	input  wire  [dedc_pkg::CH_W-1:0]           in_ch,
	input  wire                                 in_last,
	input  wire                                 cfg_we,
	input  wire  [dedc_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  wire  [dedc_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire                                 out_ready,
	output logic                                out_valid,
	output logic                                out_is_dga,
	output logic [dedc_pkg::CAUSE_W-1:0]        out_cause,
	output logic [dedc_pkg::ENT_W-1:0]          out_entropy,
	output logic [dedc_pkg::LEN_W-1:0]          out_length,
	output logic                                out_too_long
);
	import dedc_pkg::*;

	logic [SUM_W-1:0] term_tab [256];

	for (genvar g = 0; g < 256; g++) begin : g_term
		assign term_tab[g] = SUM_W'(clog_term(g, FRAC_BITS));
	end

	// configuration
	logic [ENT_W-1:0] thr_q;
	logic [LEN_W-1:0] min_len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q     <= THRESHOLD_RST;
			min_len_q <= MIN_LEN_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_THRESHOLD: thr_q     <= cfg_data;
				REG_MIN_LEN:   min_len_q <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// histogram memory
	logic [CH_W-1:0] mem [256];
	logic [CH_W-1:0] rdata_q;
	logic [CH_W-1:0] ch_s1;
	logic            last_s1;
	logic [255:0]    cvalid_q;

	logic [CH_W-1:0] cnt_cur;
	logic [CH_W-1:0] cnt_inc;
	logic            do_upd;

	assign cnt_cur = cvalid_q[ch_s1] ? rdata_q : '0;
	assign cnt_inc = cnt_cur + 1'b1;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			rdata_q <= mem[in_ch];
			ch_s1   <= in_ch;
			last_s1 <= in_last;
		end
		if (do_upd)
			mem[ch_s1] <= cnt_inc;
	end

	// per-name state
	logic [SUM_W-1:0] log_sum_q;
	logic [LEN_W-1:0] len_q;
	logic [2:0]       drun_q;
	logic [4:0]       lrun_q;
	logic [5:0]       lcnt_q;
	logic             in_first_q;
	logic [2:0]       hits_q;
	logic             ovf_q;

	logic is_digit;
	logic is_lower;
	logic [2:0] drun_n;
	logic [4:0] lrun_n;

	assign is_digit = (in_ch >= 8'h30) && (in_ch <= 8'h39);
	assign is_lower = (in_ch >= 8'h61) && (in_ch <= 8'h7a);
	assign drun_n   = (drun_q < 3'd5) ? drun_q + 1'b1 : drun_q;
	assign lrun_n   = (lrun_q < 5'd20) ? lrun_q + 1'b1 : lrun_q;
	assign do_upd   = cmd.update && !ovf_q && (cnt_cur != 8'hFF);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cvalid_q   <= '0;
			log_sum_q  <= '0;
			len_q      <= '0;
			drun_q     <= '0;
			lrun_q     <= '0;
			lcnt_q     <= '0;
			in_first_q <= 1'b1;
			hits_q     <= '0;
			ovf_q      <= 1'b0;
		end else if (cmd.finish) begin
			cvalid_q   <= '0;
			log_sum_q  <= '0;
			len_q      <= '0;
			drun_q     <= '0;
			lrun_q     <= '0;
			lcnt_q     <= '0;
			in_first_q <= 1'b1;
			hits_q     <= '0;
			ovf_q      <= 1'b0;
		end else begin
			if (cmd.accept) begin
				if (len_q >= LEN_W'(MAX_NAME_LEN))
					ovf_q <= 1'b1;
				if (len_q != 8'hFF)
					len_q <= len_q + 1'b1;
				if (is_digit) begin
					drun_q <= drun_n;
					if (drun_n >= 3'd5)
						hits_q[0] <= 1'b1;
				end else begin
					drun_q <= '0;
				end
				if (is_lower) begin
					lrun_q <= lrun_n;
					if (lrun_n >= 5'd20)
						hits_q[1] <= 1'b1;
				end else begin
					lrun_q <= '0;
				end
				if (in_first_q) begin
					if (is_digit || is_lower) begin
						if (lcnt_q < 6'd32)
							lcnt_q <= lcnt_q + 1'b1;
					end else begin
						if ((in_ch == 8'h2e) && (lcnt_q >= 6'd32))
							hits_q[2] <= 1'b1;
						in_first_q <= 1'b0;
					end
				end
			end
			if (do_upd) begin
				log_sum_q        <= log_sum_q + term_tab[cnt_inc] - term_tab[cnt_cur];
				cvalid_q[ch_s1]  <= 1'b1;
			end
		end
	end

	// restoring divider, one quotient bit per step
	logic [SUM_W-1:0] div_q;
	logic [LEN_W-1:0] rem_q;
	logic [SUM_W-1:0] whole;
	logic [SUM_W-1:0] numer;
	logic [LEN_W:0]   rem_sh;
	logic             qbit;

	assign whole  = term_tab[len_q];
	assign numer  = (whole > log_sum_q) ? whole - log_sum_q : '0;
	assign rem_sh = {rem_q, div_q[SUM_W-1]};
	assign qbit   = rem_sh >= {1'b0, len_q};

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			div_q <= numer + SUM_W'(len_q >> 1);
			rem_q <= '0;
		end else if (cmd.step) begin
			div_q <= {div_q[SUM_W-2:0], qbit};
			rem_q <= qbit ? LEN_W'(rem_sh - {1'b0, len_q}) : rem_sh[LEN_W-1:0];
		end
	end

	// verdict and result register
	logic [ENT_W-1:0] ent;
	logic [ENT_W-1:0] ent_sat;
	cause_t           cause;

	assign ent_sat = (|div_q[SUM_W-1:ENT_W]) ? '1 : div_q[ENT_W-1:0];
	assign ent     = ovf_q ? '0 : ent_sat;

	always_comb begin
		cause = CAUSE_NONE;
		if (!ovf_q && (len_q >= min_len_q)) begin
			if (ent > thr_q)
				cause = CAUSE_ENTROPY;
			else if (hits_q[0])
				cause = CAUSE_DIGITS;
			else if (hits_q[1])
				cause = CAUSE_LETTERS;
			else if (hits_q[2])
				cause = CAUSE_LABEL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (cmd.finish)
			out_valid <= 1'b1;
		else if (out_ready)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_is_dga   <= (cause != CAUSE_NONE);
			out_cause    <= cause;
			out_entropy  <= ent;
			out_length   <= len_q;
			out_too_long <= ovf_q;
		end
	end

	assign stat.last     = last_s1;
	assign stat.out_free = !out_valid || out_ready;

endmodule

`default_nettype wire

// File: hw/rtl/dedc_checker.sv
// dedc_checker: port-level assertions on the classifier results, bound to the top level
// depends on dedc_pkg
`default_nettype none

module dedc_checker (
	input wire                            clk,
	input wire                            arst_n,
	input wire                            out_valid,
	input wire                            out_ready,
	input wire                            is_dga,
	input wire [dedc_pkg::CAUSE_W-1:0]    cause,
	input wire [dedc_pkg::ENT_W-1:0]      entropy_q,
	input wire [dedc_pkg::LEN_W-1:0]      name_length,
	input wire                            too_long
);
	import dedc_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (is_dga == (cause != CAUSE_NONE)))
		else $error("verdict and cause disagree");

	a_too_long: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && too_long |-> !is_dga && (entropy_q == '0))
		else $error("too long name judged");

	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (name_length != '0) && (cause <= CAUSE_LABEL))
		else $error("bad result length or cause");

endmodule

bind dga_domain_entropy_classifier_top dedc_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (result_out.valid),
	.out_ready  (result_out.ready),
	.is_dga     (result_out.is_dga),
	.cause      (result_out.cause),
	.entropy_q  (result_out.entropy_q),
	.name_length(result_out.name_length),
	.too_long   (result_out.too_long)
);

`default_nettype wire
